[sv/coo_to_csr_converter_top_assert.svh]
// ----------------------------------------------------------------------------
// coo_to_csr_converter_top_assert.svh
// Assertion macros shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef COO_TO_CSR_CONVERTER_TOP_ASSERT_SVH
`define COO_TO_CSR_CONVERTER_TOP_ASSERT_SVH

// expr must hold at every edge outside reset
`define C2C_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("c2c assertion failed");

// ante in one cycle implies cons in the next
`define C2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2c assertion failed");

`endif

[sv/c2c_pkg.sv]
// ----------------------------------------------------------------------------
// c2c_pkg
// Shared types and constants of the COO to CSR converter.
// ----------------------------------------------------------------------------
package c2c_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_COL_BITS    = 16;

    localparam int IDX_W   = 11;
    localparam int COL_W   = 16;
    localparam int VALUE_W = 64;

    typedef enum logic [1:0] {
        OP_LOAD       = 2'd0,
        OP_CONVERT    = 2'd1,
        OP_READ_PTR   = 2'd2,
        OP_READ_ENTRY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_FULL         = 2'd1,
        STS_BAD_ROW      = 2'd2,
        STS_READ_INVALID = 2'd3
    } status_t;

endpackage

[sv/c2c_ram.sv]
// ----------------------------------------------------------------------------
// c2c_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module c2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/coo_to_csr_converter_top.sv]
// ----------------------------------------------------------------------------
// coo_to_csr_converter_top
// Loads coordinate triplets, converts them to CSR form and serves reads.
// ----------------------------------------------------------------------------
// Load results go straight into the output register; pointer and entry reads
// first pass the registered read of the row-pointer and CSR memories. A convert
// runs as a sequencer over the triplet memory and holds the input side off
// until it is done with the n loaded entries:
// a clearing sweep of the row-pointer memory, a read-modify-write histogram,
// a prefix-sum sweep, and a rank pass in which every entry scans all n
// entries of the triplet memory, one read per cycle, to find its CSR slot.
module coo_to_csr_converter_top
    import c2c_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int COL_BITS    = DEF_COL_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // triplet_row[10:0], triplet_col[26:11], triplet_value[90:27],
    // read_index[101:91], zero pad [103:102]
    input  logic [103:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_total[10:0], entry_total[21:11], row_pointer[32:22],
    // entry_col[48:33], entry_value[112:49], zero pad [119:113]
    output logic [119:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PW  = $clog2(MAX_ROWS + 1);
    localparam int LDW = RW + COL_BITS + VALUE_W;
    localparam int CSW = COL_BITS + VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_CLR, S_H_RD, S_H_UPD, S_H_WR, S_P_RD, S_P_WR,
        S_K_RD, S_K_LAT, S_K_SCAN, S_K_WR, S_DONE
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       cnt_reg;
    logic [PW-1:0]       rows_seen_reg;
    logic                converted_reg;
    logic [PW-1:0]       top_reg;
    logic [PW-1:0]       k_reg;
    logic [PW-1:0]       hrow_reg;
    logic [CW-1:0]       acc_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       j_reg;
    logic [CW-1:0]       cmp_idx_reg;
    logic                cmp_v_reg;
    logic [CW-1:0]       rank_reg;
    logic [LDW-1:0]      key_reg;
    logic                rd_ok_reg;
    op_t                 rd_op_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [IDX_W-1:0]    out_rows_reg;
    logic [IDX_W-1:0]    out_ents_reg;
    logic [IDX_W-1:0]    out_ptr_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [VALUE_W-1:0]  out_val_reg;

    op_t                 op;
    logic [IDX_W-1:0]    trow;
    logic [COL_W-1:0]    tcol;
    logic [VALUE_W-1:0]  tval;
    logic [IDX_W-1:0]    ridx;
    logic                s_fire;
    logic [CW-1:0]       eff_cnt;
    logic                bad_row;
    logic                full;
    logic                ptr_ok;
    logic                ent_ok;
    logic                out_load;

    logic                ld_we;
    logic [AW-1:0]       ld_raddr;
    logic [LDW-1:0]      ld_wdata;
    logic [LDW-1:0]      ld_q;
    logic [RW-1:0]       q_row;
    logic [RW+COL_BITS-1:0] q_key;
    logic [RW+COL_BITS-1:0] k_key;
    logic                goes_before;

    logic                rs_we;
    logic [PW-1:0]       rs_waddr;
    logic [CW-1:0]       rs_wdata;
    logic [PW-1:0]       rs_raddr;
    logic [CW-1:0]       rs_q;
    logic [CW-1:0]       acc_next;

    logic                csr_we;
    logic [CSW-1:0]      csr_q;

    assign op   = op_t'(s_tuser);
    assign trow = s_tdata[10:0];
    assign tcol = s_tdata[26:11];
    assign tval = s_tdata[90:27];
    assign ridx = s_tdata[101:91];

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    assign eff_cnt = converted_reg ? '0 : cnt_reg;
    assign bad_row = (trow == '0) || (32'(trow) > MAX_ROWS);
    assign full    = (32'(eff_cnt) >= MAX_ENTRIES);
    assign ptr_ok  = converted_reg && (32'(ridx) <= 32'(rows_seen_reg))
                     && (32'(ridx) <= MAX_ROWS);
    assign ent_ok  = converted_reg && (32'(ridx) < 32'(cnt_reg));

    // a result is loaded into the output register in these cycles
    assign out_load = ((state_reg == S_IDLE) && s_fire && (op == OP_LOAD))
                      || (state_reg == S_RDWAIT) || (state_reg == S_DONE);

    // triplet memory: {row, col, value}
    assign ld_we    = s_fire && (op == OP_LOAD) && !bad_row && !full;
    assign ld_wdata = {RW'(trow - 11'd1), COL_BITS'(tcol), tval};
    assign ld_raddr = (state_reg == S_K_SCAN) ? j_reg[AW-1:0] : i_reg[AW-1:0];
    assign q_row    = ld_q[VALUE_W+COL_BITS +: RW];
    assign q_key    = ld_q[VALUE_W +: RW+COL_BITS];
    assign k_key    = key_reg[VALUE_W +: RW+COL_BITS];
    // stable order: smaller key, or equal key loaded earlier
    assign goes_before = (q_key < k_key) || ((q_key == k_key) && (cmp_idx_reg < i_reg));

    c2c_ram #(.WIDTH(LDW), .DEPTH(MAX_ENTRIES)) u_load_ram (
        .clk   (clk),
        .we    (ld_we),
        .waddr (eff_cnt[AW-1:0]),
        .wdata (ld_wdata),
        .raddr (ld_raddr),
        .rdata (ld_q)
    );

    assign acc_next = acc_reg + rs_q;

    always_comb
    begin
        rs_we    = 1'b0;
        rs_waddr = k_reg;
        rs_wdata = '0;
        rs_raddr = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                rs_raddr = PW'(ridx);
            end
            S_CLR:
            begin
                rs_we = 1'b1;
            end
            S_H_UPD:
            begin
                rs_raddr = PW'(q_row) + PW'(1);
            end
            S_H_WR:
            begin
                rs_we    = 1'b1;
                rs_waddr = hrow_reg;
                rs_wdata = rs_q + CW'(1);
            end
            S_P_WR:
            begin
                rs_we    = 1'b1;
                rs_wdata = acc_next;
            end
            default:
            begin
                rs_we = 1'b0;
            end
        endcase
    end

    c2c_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS + 1)) u_ptr_ram (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (rs_wdata),
        .raddr (rs_raddr),
        .rdata (rs_q)
    );

    assign csr_we = (state_reg == S_K_WR);

    c2c_ram #(.WIDTH(CSW), .DEPTH(MAX_ENTRIES)) u_csr_ram (
        .clk   (clk),
        .we    (csr_we),
        .waddr (rank_reg[AW-1:0]),
        .wdata (key_reg[CSW-1:0]),
        .raddr (AW'(ridx)),
        .rdata (csr_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rows_seen_reg  <= '0;
            converted_reg  <= 1'b0;
            top_reg        <= '0;
            k_reg          <= '0;
            hrow_reg       <= '0;
            acc_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            cmp_idx_reg    <= '0;
            cmp_v_reg      <= 1'b0;
            rank_reg       <= '0;
            key_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            rd_op_reg      <= OP_LOAD;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STS_OK;
            out_rows_reg   <= '0;
            out_ents_reg   <= '0;
            out_ptr_reg    <= '0;
            out_col_reg    <= '0;
            out_val_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        case (op)
                            OP_LOAD:
                            begin
                                if (converted_reg)
                                begin
                                    rows_seen_reg <= '0;
                                    converted_reg <= 1'b0;
                                end
                                out_ptr_reg   <= '0;
                                out_col_reg   <= '0;
                                out_val_reg   <= '0;
                                out_rows_reg  <= converted_reg ? '0 : IDX_W'(rows_seen_reg);
                                if (bad_row)
                                begin
                                    cnt_reg        <= eff_cnt;
                                    out_status_reg <= STS_BAD_ROW;
                                    out_ents_reg   <= IDX_W'(eff_cnt);
                                end
                                else if (full)
                                begin
                                    cnt_reg        <= eff_cnt;
                                    out_status_reg <= STS_FULL;
                                    out_ents_reg   <= IDX_W'(eff_cnt);
                                end
                                else
                                begin
                                    cnt_reg        <= eff_cnt + CW'(1);
                                    out_status_reg <= STS_OK;
                                    out_ents_reg   <= IDX_W'(eff_cnt + CW'(1));
                                end
                            end
                            OP_CONVERT:
                            begin
                                k_reg     <= '0;
                                state_reg <= S_CLR;
                            end
                            OP_READ_PTR:
                            begin
                                rd_ok_reg <= ptr_ok;
                                rd_op_reg <= op;
                                state_reg <= S_RDWAIT;
                            end
                            default:
                            begin
                                rd_ok_reg <= ent_ok;
                                rd_op_reg <= op;
                                state_reg <= S_RDWAIT;
                            end
                        endcase
                    end
                end
                S_RDWAIT:
                begin
                    out_status_reg <= rd_ok_reg ? STS_OK : STS_READ_INVALID;
                    out_rows_reg   <= IDX_W'(rows_seen_reg);
                    out_ents_reg   <= IDX_W'(cnt_reg);
                    out_ptr_reg    <= (rd_ok_reg && (rd_op_reg == OP_READ_PTR))
                                      ? IDX_W'(rs_q) : '0;
                    out_col_reg    <= (rd_ok_reg && (rd_op_reg == OP_READ_ENTRY))
                                      ? COL_W'(csr_q[VALUE_W +: COL_BITS]) : '0;
                    out_val_reg    <= (rd_ok_reg && (rd_op_reg == OP_READ_ENTRY))
                                      ? csr_q[VALUE_W-1:0] : '0;
                    state_reg <= S_IDLE;
                end
                S_CLR:
                begin
                    if (32'(k_reg) == MAX_ROWS)
                    begin
                        i_reg   <= '0;
                        top_reg <= '0;
                        k_reg   <= '0;
                        acc_reg <= '0;
                        state_reg <= (cnt_reg == '0) ? S_P_RD : S_H_RD;
                    end
                    else
                    begin
                        k_reg <= k_reg + PW'(1);
                    end
                end
                S_H_RD:
                begin
                    state_reg <= S_H_UPD;
                end
                S_H_UPD:
                begin
                    hrow_reg <= PW'(q_row) + PW'(1);
                    if ((PW'(q_row) + PW'(1)) > top_reg)
                    begin
                        top_reg <= PW'(q_row) + PW'(1);
                    end
                    state_reg <= S_H_WR;
                end
                S_H_WR:
                begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= ((i_reg + CW'(1)) == cnt_reg) ? S_P_RD : S_H_RD;
                end
                S_P_RD:
                begin
                    state_reg <= S_P_WR;
                end
                S_P_WR:
                begin
                    acc_reg <= acc_next;
                    k_reg   <= k_reg + PW'(1);
                    if (k_reg == top_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= (cnt_reg == '0) ? S_DONE : S_K_RD;
                    end
                    else
                    begin
                        state_reg <= S_P_RD;
                    end
                end
                S_K_RD:
                begin
                    state_reg <= S_K_LAT;
                end
                S_K_LAT:
                begin
                    key_reg   <= ld_q;
                    j_reg     <= '0;
                    cmp_v_reg <= 1'b0;
                    rank_reg  <= '0;
                    state_reg <= S_K_SCAN;
                end
                S_K_SCAN:
                begin
                    // issue the next read and count the entry read last cycle
                    if (j_reg < cnt_reg)
                    begin
                        j_reg       <= j_reg + CW'(1);
                        cmp_idx_reg <= j_reg;
                        cmp_v_reg   <= 1'b1;
                    end
                    else
                    begin
                        cmp_v_reg <= 1'b0;
                    end
                    if (cmp_v_reg && goes_before)
                    begin
                        rank_reg <= rank_reg + CW'(1);
                    end
                    if ((j_reg >= cnt_reg) && !cmp_v_reg)
                    begin
                        state_reg <= S_K_WR;
                    end
                end
                S_K_WR:
                begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= ((i_reg + CW'(1)) == cnt_reg) ? S_DONE : S_K_RD;
                end
                S_DONE:
                begin
                    rows_seen_reg  <= top_reg;
                    converted_reg  <= 1'b1;
                    out_status_reg <= STS_OK;
                    out_rows_reg   <= IDX_W'(top_reg);
                    out_ents_reg   <= IDX_W'(cnt_reg);
                    out_ptr_reg    <= '0;
                    out_col_reg    <= '0;
                    out_val_reg    <= '0;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_val_reg, out_col_reg, out_ptr_reg,
                       out_ents_reg, out_rows_reg};

`include "coo_to_csr_converter_top_assert.svh"

    `C2C_ASSERT_NEXT(a_convert_no_early_result, clk, rst_n, s_fire && (op == OP_CONVERT), !m_tvalid)
    `C2C_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, 32'(cnt_reg) <= MAX_ENTRIES)
    `C2C_ASSERT_ALWAYS(a_rank_in_range, clk, rst_n, (state_reg != S_K_WR) || (rank_reg < cnt_reg))
    `C2C_ASSERT_ALWAYS(a_rows_in_range, clk, rst_n, 32'(rows_seen_reg) <= MAX_ROWS)

endmodule

[verif/tb_coo_to_csr_converter_top.sv]
// ----------------------------------------------------------------------------
// tb_coo_to_csr_converter_top
// Self-checking bench for the COO to CSR converter: a directed table of
// items, random matrices that are loaded, converted and read back, then a
// fill and overflow of the triplet store. A transaction-level model predicts
// every result. The receiver stalls and the sender idles at random in several phases.
// ----------------------------------------------------------------------------
module tb_coo_to_csr_converter_top;
    import c2c_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT  = DEF_MAX_ENTRIES;
    localparam int NROWS = DEF_MAX_ROWS;

    typedef struct {
        status_t                  sts;
        logic [IDX_W-1:0]         rows;
        logic [IDX_W-1:0]         ents;
        logic [IDX_W-1:0]         ptr;
        logic [COL_W-1:0]         col;
        logic [VALUE_W-1:0]       val;
    } csr_result_t;

    typedef struct {
        op_t                op;
        logic [IDX_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] val;
        logic [IDX_W-1:0]   idx;
        bit                 typed;
        status_t            sts;
    } dir_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;

    coo_to_csr_converter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // model state
    logic [9:0]         trip_row [NENT];
    logic [COL_W-1:0]   trip_col [NENT];
    logic [VALUE_W-1:0] trip_val [NENT];
    int                 n_loaded;
    int                 n_rows;
    int                 row_start [NROWS+1];
    logic [COL_W-1:0]   sorted_col [NENT];
    logic [VALUE_W-1:0] sorted_val [NENT];
    bit                 is_converted;

    csr_result_t pending_results[$];
    int          n_errors;
    int          idle_pct;
    int          stall_pct;
    int          rand_items;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit sorts_after(int a, int b);
        if (trip_row[a] != trip_row[b])
            return trip_row[a] > trip_row[b];
        return trip_col[a] > trip_col[b];
    endfunction

    task automatic set_phase(input int phase);
        case (phase)
            0:
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct = 64;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct = 0;
                stall_pct = 64;
            end
            default:
            begin
                idle_pct = 9;
                stall_pct = 9;
            end
        endcase
    endtask

    task automatic build_csr();
        int order [NENT];
        int top;
        int j;
        int key;
        top = 0;
        for (int i = 0; i < n_loaded; i++)
            if (int'(trip_row[i]) + 1 > top)
                top = int'(trip_row[i]) + 1;
        n_rows = top;
        for (int i = 0; i <= NROWS; i++)
            row_start[i] = 0;
        for (int i = 0; i < n_loaded; i++)
            row_start[trip_row[i] + 1]++;
        for (int i = 0; i < top; i++)
            row_start[i + 1] += row_start[i];
        // stable insertion by (row, column)
        for (int i = 0; i < n_loaded; i++)
        begin
            key = i;
            j = i;
            while (j > 0 && sorts_after(order[j-1], key))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        for (int i = 0; i < n_loaded; i++)
        begin
            sorted_col[i] = trip_col[order[i]];
            sorted_val[i] = trip_val[order[i]];
        end
        is_converted = 1'b1;
    endtask

    task automatic predict_item(input op_t op, input logic [IDX_W-1:0] row,
                                input logic [COL_W-1:0] col,
                                input logic [VALUE_W-1:0] val,
                                input logic [IDX_W-1:0] idx,
                                output csr_result_t r);
        r.sts = STS_OK;
        r.ptr = '0;
        r.col = '0;
        r.val = '0;
        case (op)
            OP_LOAD:
            begin
                if (is_converted)
                begin
                    n_loaded = 0;
                    n_rows = 0;
                    is_converted = 1'b0;
                end
                if (row == 0 || row > NROWS)
                    r.sts = STS_BAD_ROW;
                else if (n_loaded >= NENT)
                    r.sts = STS_FULL;
                else
                begin
                    trip_row[n_loaded] = 10'(row - 1);
                    trip_col[n_loaded] = col;
                    trip_val[n_loaded] = val;
                    n_loaded++;
                end
            end
            OP_CONVERT: build_csr();
            OP_READ_PTR:
            begin
                if (is_converted && idx <= n_rows)
                    r.ptr = IDX_W'(row_start[idx]);
                else
                    r.sts = STS_READ_INVALID;
            end
            default:
            begin
                if (is_converted && idx < n_loaded)
                begin
                    r.col = sorted_col[idx];
                    r.val = sorted_val[idx];
                end
                else
                    r.sts = STS_READ_INVALID;
            end
        endcase
        r.rows = IDX_W'(n_rows);
        r.ents = IDX_W'(n_loaded);
    endtask

    // call right after a rising edge; returns right after the accepting edge
    task automatic send_item(input op_t op, input logic [IDX_W-1:0] row,
                             input logic [COL_W-1:0] col,
                             input logic [VALUE_W-1:0] val,
                             input logic [IDX_W-1:0] idx,
                             input bit typed, input status_t sts);
        csr_result_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, idx, val, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(op, row, col, val, idx, r);
        if (typed)
            r.sts = sts;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        csr_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                n_errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser != e.sts)
                begin
                    $error("status: expected %0d, got %0d", e.sts, m_tuser);
                    n_errors++;
                end
                if (m_tdata[10:0] != e.rows)
                begin
                    $error("row_total: expected %0d, got %0d", e.rows, m_tdata[10:0]);
                    n_errors++;
                end
                if (m_tdata[21:11] != e.ents)
                begin
                    $error("entry_total: expected %0d, got %0d", e.ents, m_tdata[21:11]);
                    n_errors++;
                end
                if (m_tdata[32:22] != e.ptr)
                begin
                    $error("row_pointer: expected %0d, got %0d", e.ptr, m_tdata[32:22]);
                    n_errors++;
                end
                if (m_tdata[48:33] != e.col)
                begin
                    $error("entry_col: expected %h, got %h", e.col, m_tdata[48:33]);
                    n_errors++;
                end
                if (m_tdata[112:49] != e.val)
                begin
                    $error("entry_value: expected %h, got %h", e.val, m_tdata[112:49]);
                    n_errors++;
                end
            end
        end
    end

    // one random matrix: loads, convert, reads, with noise mixed in
    task automatic run_matrix();
        int n;
        int span;
        int nreads;
        logic [IDX_W-1:0] row;
        logic [COL_W-1:0] col;
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
        span = ($urandom_range(7) == 0) ? NROWS : $urandom_range(12, 1);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0: row = ($urandom_range(1) == 0) ? 11'd0 : IDX_W'($urandom_range(2047, 1025));
                1: row = IDX_W'(NROWS);
                default: row = IDX_W'($urandom_range(span, 1));
            endcase
            col = ($urandom_range(1) == 0) ? COL_W'($urandom_range(6)) : COL_W'($urandom);
            send_item(OP_LOAD, row, col, {$urandom, $urandom}, IDX_W'($urandom), 0, STS_OK);
            rand_items++;
        end
        if ($urandom_range(4) == 0)
        begin
            send_item(OP_READ_ENTRY, IDX_W'($urandom), COL_W'($urandom), {$urandom, $urandom},
                      IDX_W'($urandom_range(3)), 0, STS_OK);
            rand_items++;
        end
        send_item(OP_CONVERT, IDX_W'($urandom), COL_W'($urandom), {$urandom, $urandom},
                  IDX_W'($urandom), 0, STS_OK);
        rand_items++;
        if ($urandom_range(5) == 0)
        begin
            send_item(OP_CONVERT, '0, '0, '0, '0, 0, STS_OK);
            rand_items++;
        end
        nreads = n + $urandom_range(8, 2);
        for (int i = 0; i < nreads; i++)
        begin
            if ($urandom_range(1) == 0)
                send_item(OP_READ_PTR, IDX_W'($urandom), COL_W'($urandom), {$urandom, $urandom},
                          ($urandom_range(9) == 0) ? IDX_W'($urandom)
                                                   : IDX_W'($urandom_range(n_rows + 1)),
                          0, STS_OK);
            else
                send_item(OP_READ_ENTRY, IDX_W'($urandom), COL_W'($urandom), {$urandom, $urandom},
                          ($urandom_range(9) == 0) ? IDX_W'($urandom)
                                                   : IDX_W'($urandom_range(n_loaded + 1)),
                          0, STS_OK);
            rand_items++;
        end
    endtask

    initial
    begin
        dir_item_t table_rows[$];
        logic [VALUE_W-1:0] ones;
        ones = '1;
        n_loaded = 0;
        n_rows = 0;
        is_converted = 1'b0;
        n_errors = 0;
        rand_items = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        m_tready = 1'b0;

        table_rows = '{
            '{OP_READ_PTR,   11'd0,    16'h0,    64'h0, 11'd0,    1, STS_READ_INVALID},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd0,    1, STS_READ_INVALID},
            '{OP_CONVERT,    11'd0,    16'h0,    64'h0, 11'd0,    1, STS_OK},
            '{OP_READ_PTR,   11'd0,    16'h0,    64'h0, 11'd0,    1, STS_OK},
            '{OP_READ_PTR,   11'd0,    16'h0,    64'h0, 11'd1,    1, STS_READ_INVALID},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd0,    1, STS_READ_INVALID},
            '{OP_LOAD,       11'd0,    16'h1,    64'h1, 11'd0,    1, STS_BAD_ROW},
            '{OP_LOAD,       11'd1025, 16'h2,    64'h2, 11'd0,    1, STS_BAD_ROW},
            '{OP_LOAD,       11'd2047, 16'hffff, ones,  11'd2047, 1, STS_BAD_ROW},
            '{OP_LOAD,       11'd1024, 16'hffff, ones,  11'd0,    1, STS_OK},
            '{OP_LOAD,       11'd1,    16'h0,    64'h0, 11'd0,    1, STS_OK},
            '{OP_LOAD,       11'd3,    16'h5,    64'hA, 11'd0,    1, STS_OK},
            '{OP_LOAD,       11'd3,    16'h5,    64'hB, 11'd0,    1, STS_OK},
            '{OP_LOAD,       11'd3,    16'h2,    64'hC, 11'd0,    1, STS_OK},
            '{OP_LOAD,       11'd1,    16'h0,    64'hD, 11'd0,    1, STS_OK},
            '{OP_CONVERT,    11'd0,    16'h0,    64'h0, 11'd0,    1, STS_OK},
            '{OP_READ_PTR,   11'd0,    16'h0,    64'h0, 11'd3,    0, STS_OK},
            '{OP_READ_PTR,   11'd0,    16'h0,    64'h0, 11'd1024, 0, STS_OK},
            '{OP_READ_PTR,   11'd0,    16'h0,    64'h0, 11'd1025, 1, STS_READ_INVALID},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd1,    0, STS_OK},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd3,    0, STS_OK},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd4,    0, STS_OK},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd6,    1, STS_READ_INVALID},
            '{OP_CONVERT,    11'd0,    16'h0,    64'h0, 11'd0,    1, STS_OK},
            '{OP_READ_ENTRY, 11'd0,    16'h0,    64'h0, 11'd2,    0, STS_OK}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_item(table_rows[i].op, table_rows[i].row, table_rows[i].col,
                      table_rows[i].val, table_rows[i].idx, table_rows[i].typed,
                      table_rows[i].sts);

        for (int phase = 0; phase < 4; phase++)
        begin
            set_phase(phase);
            while (rand_items < (phase + 1) * 25)
                run_matrix();
            // hold the sender until the receiver has caught up
            drain_results();
            @(posedge clk);
        end

        // fill the triplet store and overflow it; no convert follows
        for (int i = 0; i < NENT; i++)
        begin
            set_phase(i / (NENT / 4));
            send_item(OP_LOAD, IDX_W'($urandom_range(4, 1)), COL_W'($urandom),
                      {$urandom, $urandom}, '0, 0, STS_OK);
        end
        send_item(OP_LOAD, 11'd1, 16'h7, 64'h7, '0, 1, STS_FULL);
        send_item(OP_LOAD, IDX_W'(NROWS), 16'hffff, ones, '0, 1, STS_FULL);
        send_item(OP_LOAD, 11'd0, 16'h1, 64'h1, '0, 1, STS_BAD_ROW);
        send_item(OP_READ_ENTRY, '0, '0, '0, 11'd0, 1, STS_READ_INVALID);
        send_item(OP_READ_PTR, '0, '0, '0, 11'd0, 1, STS_READ_INVALID);

        drain_results();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/c2c_pkg.sv
sv/c2c_ram.sv
sv/coo_to_csr_converter_top.sv
verif/tb_coo_to_csr_converter_top.sv
